// ----- rtl/otsh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otsh_pkg: shared types, constants and alphabet tables
// Alphabet codes, the FNV-1a 64 offset basis, divider sizing and the control
// structs passed between the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package otsh_pkg;

	localparam int DEFAULT_MAX_WIDTH = 16;

	// configuration register indexes
	localparam logic REG_ALPHABET_SELECT = 1'b0;
	localparam logic REG_STRING_WIDTH    = 1'b1;

	localparam logic [4:0] STRING_WIDTH_RESET = 5'd4;

	// alphabet codes
	localparam logic [1:0] ALPHA_ORIGINAL = 2'd0;
	localparam logic [1:0] ALPHA_SAFE     = 2'd1;
	localparam logic [1:0] ALPHA_DIGITS   = 2'd2;
	localparam logic [1:0] ALPHA_LOWER    = 2'd3;

	localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;

	// divider: radix 2^DIV_STEP_BITS long division, remainder below 64
	localparam int DIVIDEND_W    = 64;
	localparam int DIV_STEP_BITS = 8;
	localparam int DIV_CYCLES    = DIVIDEND_W / DIV_STEP_BITS;
	localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);
	localparam int DIGIT_W       = 6;
	localparam int BASE_W        = 7;

	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_NEWLINE   = 8'h0a;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_LOWER_N   = 8'h6e;

	typedef struct packed {
		logic load;   // take a new dividend and start
		logic cont;   // divide the held quotient again
	} div_cmd_t;

	typedef struct packed {
		logic init;   // load the offset basis
		logic step;   // fold in one character
	} hash_cmd_t;

	function automatic logic [BASE_W-1:0] alpha_base(input logic [1:0] sel);
		logic [BASE_W-1:0] b;
		case (sel)
			ALPHA_ORIGINAL: b = 7'd64;
			ALPHA_SAFE:     b = 7'd63;
			ALPHA_DIGITS:   b = 7'd10;
			default:        b = 7'd26;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] alpha_char(input logic [1:0] sel,
		input logic [DIGIT_W-1:0] d);
		logic [7:0] dx;
		logic [7:0] c;
		dx = {2'b00, d};
		case (sel)
			ALPHA_ORIGINAL, ALPHA_SAFE: begin
				if (dx < 8'd26)
					c = CH_LOWER_A + dx;
				else if (dx < 8'd52)
					c = CH_UPPER_A + dx - 8'd26;
				else if (dx < 8'd62)
					c = CH_ZERO + dx - 8'd52;
				else if (dx == 8'd62)
					c = (sel == ALPHA_SAFE) ? CH_UNDERSCORE : CH_SPACE;
				else
					c = CH_NEWLINE;
			end
			ALPHA_DIGITS: c = CH_ZERO + dx;
			default:      c = CH_LOWER_A + dx;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/otsh_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otsh_div: iterative digit extractor
// Long division of a 64-bit value by a small base, eight dividend bits per
// cycle. The quotient replaces the dividend in place so that the next digit
// comes from a plain restart.
// ----------------------------------------------------------------------------
module otsh_div (
	input  wire                               clk,
	input  wire                               arst_n,
	input  otsh_pkg::div_cmd_t                cmd,
	input  wire [otsh_pkg::DIVIDEND_W-1:0]    dividend,
	input  wire [otsh_pkg::BASE_W-1:0]        base,
	output logic                              done,
	output logic [otsh_pkg::DIGIT_W-1:0]      digit
);
	import otsh_pkg::*;

	logic                      busy_q;
	logic                      done_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0]     num_q;
	logic [DIGIT_W-1:0]        rem_q;
	logic [DIGIT_W-1:0]        rem_nxt;
	logic [DIV_STEP_BITS-1:0]  qbits;

	// eight restoring steps on the 7-bit partial remainder
	always_comb begin
		logic [BASE_W-1:0] t;
		rem_nxt = rem_q;
		qbits   = '0;
		for (int j = 0; j < DIV_STEP_BITS; j++) begin
			t = {rem_nxt, num_q[DIVIDEND_W-1-j]};
			if (t >= base) begin
				t = t - base;
				qbits[DIV_STEP_BITS-1-j] = 1'b1;
			end
			rem_nxt = t[DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.load || cmd.cont) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (cmd.cont) begin
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIVIDEND_W-DIV_STEP_BITS-1:0], qbits};
			rem_q <= rem_nxt;
		end
	end

	assign done  = done_q;
	assign digit = rem_q;

endmodule
`default_nettype wire

// ----- rtl/otsh_hash.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otsh_hash: FNV-1a 64 accumulator
// One character per step: xor into the low byte, then multiply by the
// FNV prime, done as a fixed shift-and-add.
// ----------------------------------------------------------------------------
module otsh_hash (
	input  wire                  clk,
	input  otsh_pkg::hash_cmd_t  cmd,
	input  wire [7:0]            ch,
	output logic [63:0]          hash
);
	import otsh_pkg::*;

	logic [63:0] hash_q;
	logic [63:0] x;
	logic [63:0] prod;

	// prime = 2^40 + 0x1b3, 0x1b3 has bits 8,7,5,4,1,0
	always_comb begin
		x    = hash_q ^ {56'd0, ch};
		prod = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
	end

	always_ff @(posedge clk) begin
		if (cmd.init)
			hash_q <= FNV_OFFSET;
		else if (cmd.step)
			hash_q <= prod;
	end

	assign hash = hash_q;

endmodule
`default_nettype wire

// ----- rtl/ordinal_to_string_fnv1a_hasher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordinal_to_string_fnv1a_hasher: keyspace string generator with FNV-1a 64
// Writes an ordinal in the selected alphabet and streams the escaped bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one 64-bit ordinal per item.
//   Output channel out_valid/out_ready carries one escaped byte per item;
//   last marks the final byte of a string and hash_value then holds the
//   FNV-1a 64 of the unescaped characters (zero on other bytes).
//   Registers are written through wr_en/wr_index/wr_data while idle:
//   index 0 alphabet select, index 1 string width (0 counts as 1, values
//   above MAX_WIDTH saturate).
// Sequence, for a string of W characters:
//   each digit comes from the shared divider (a restart, then 8 dividend
//   bits per cycle), then the characters pass through the hash unit in
//   order, then the output register sends W to 2*W bytes and waits while
//   the receiver stalls. in_ready is high only while no ordinal is in
//   progress.
// Reset clears the sequencer and the output register and restores the
// alphabet to original and the width to 4. A stalled receiver holds the
// current byte in the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module ordinal_to_string_fnv1a_hasher #(
	parameter int MAX_WIDTH = otsh_pkg::DEFAULT_MAX_WIDTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         wr_en,
	input  wire         wr_index,
	input  wire [4:0]   wr_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire [63:0]  ordinal,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  out_byte,
	output logic [63:0] hash_value,
	output logic        last
);
	import otsh_pkg::*;

	localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HASH, ST_EMIT} state_t;

	state_t                state_q;
	logic [1:0]            alpha_sel_q;
	logic [4:0]            string_width_q;
	logic [IDX_W-1:0]      lidx_q;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  esc_q;
	logic [7:0]            chars_q [MAX_WIDTH];
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic [63:0]           hash_value_q;
	logic                  last_q;

	logic                  accept;
	logic                  slot_free;
	logic [IDX_W-1:0]      w_last;
	logic [5:0]            sw_ext;
	logic [7:0]            cur_ch;
	logic                  final_ch;
	div_cmd_t              div_cmd;
	logic                  div_done;
	logic [DIGIT_W-1:0]    div_digit;
	hash_cmd_t             hash_cmd;
	logic [63:0]           hash_cur;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_sel_q    <= ALPHA_ORIGINAL;
			string_width_q <= STRING_WIDTH_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ALPHABET_SELECT: alpha_sel_q    <= wr_data[1:0];
				REG_STRING_WIDTH:    string_width_q <= wr_data;
				default: ;
			endcase
		end
	end

	// index of the last character after clamping the width
	always_comb begin
		sw_ext = {1'b0, string_width_q};
		if (sw_ext == 6'd0)
			w_last = '0;
		else if (sw_ext > 6'(MAX_WIDTH))
			w_last = IDX_W'(MAX_WIDTH - 1);
		else
			w_last = IDX_W'(sw_ext - 6'd1);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign cur_ch    = chars_q[idx_q];
	assign final_ch  = (idx_q == lidx_q);

	// {load, cont} and {init, step}
	assign div_cmd  = {accept, (state_q == ST_DIV) && div_done && (pos_q != '0)};
	assign hash_cmd = {accept, (state_q == ST_HASH)};

	otsh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (ordinal),
		.base     (alpha_base(alpha_sel_q)),
		.done     (div_done),
		.digit    (div_digit)
	);

	otsh_hash u_hash (
		.clk  (clk),
		.cmd  (hash_cmd),
		.ch   (cur_ch),
		.hash (hash_cur)
	);

	// digits arrive least significant first, filled from the right
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_done)
			chars_q[pos_q] <= alpha_char(alpha_sel_q, div_digit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			lidx_q       <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
			esc_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			hash_value_q <= '0;
			last_q       <= 1'b0;
		end else begin
			// outside EMIT the output register only drains
			if (state_q != ST_EMIT && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						lidx_q  <= w_last;
						pos_q   <= w_last;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (pos_q == '0) begin
							idx_q   <= '0;
							state_q <= ST_HASH;
						end else begin
							pos_q <= pos_q - 1'b1;
						end
					end
				end
				ST_HASH: begin
					if (final_ch) begin
						idx_q   <= '0;
						esc_q   <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (cur_ch == CH_NEWLINE && !esc_q) begin
							// newline goes out as backslash, n
							out_byte_q   <= CH_BACKSLASH;
							hash_value_q <= '0;
							last_q       <= 1'b0;
							esc_q        <= 1'b1;
						end else begin
							out_byte_q   <= esc_q ? CH_LOWER_N : cur_ch;
							hash_value_q <= final_ch ? hash_cur : 64'd0;
							last_q       <= final_ch;
							esc_q        <= 1'b0;
							if (final_ch)
								state_q <= ST_IDLE;
							else
								idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign hash_value = hash_value_q;
	assign last       = last_q;

endmodule
`default_nettype wire
